// ===== sv/rsp_packet_receiver_macros.svh =====
// Assertion helpers shared by the packet receiver RTL.
`ifndef RSP_PACKET_RECEIVER_MACROS_SVH
`define RSP_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rsp_pkg;

  // Framing characters
  localparam logic [7:0] CHAR_START   = 8'h24;  // '$'
  localparam logic [7:0] CHAR_END     = 8'h23;  // '#'
  localparam logic [7:0] CHAR_ESC     = 8'h7d;
  localparam logic [7:0] ESC_XOR      = 8'h20;
  localparam logic [7:0] CHAR_BREAK   = 8'h03;
  localparam logic [7:0] CHAR_ACK     = 8'h2b;  // '+'
  localparam logic [7:0] CHAR_NAK     = 8'h2d;  // '-'

  // Input kinds
  localparam logic KIND_BYTE = 1'b0;

  // Result event codes
  localparam logic [2:0] EV_PAYLOAD = 3'd0;
  localparam logic [2:0] EV_ACCEPT  = 3'd1;
  localparam logic [2:0] EV_REJECT  = 3'd2;
  localparam logic [2:0] EV_BREAK   = 3'd3;
  localparam logic [2:0] EV_ABORT   = 3'd4;

  // Reject reasons
  localparam logic [1:0] RSN_NONE     = 2'd0;
  localparam logic [1:0] RSN_BAD_HEX  = 2'd1;
  localparam logic [1:0] RSN_OVERFLOW = 2'd2;
  localparam logic [1:0] RSN_MISMATCH = 2'd3;

  localparam int LEN_W = 13;

  typedef struct packed {
    logic [2:0]       event_res;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] packet_length;
    logic [1:0]       reject_reason;
    logic             reply_valid;
    logic [7:0]       reply_byte;
  } rsp_result_t;

  // Decode an ASCII hex digit: bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rsp_packet_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Packet framing receiver for the remote serial debug protocol. Feed one link
// beat per clock: a received byte (in_kind 0) or a link failure (in_kind 1).
// A beat taken into the input register is processed once the result register
// can take its outcome; its result, if any, is registered and offered on the
// out_ channel. The block sustains one beat per clock unless out_stall holds
// it, the rate being set by the single frame state update per beat. Payload
// bytes come out unescaped as they arrive, followed by one accept or reject
// event carrying the reply byte to return ('+' or '-', suppressed when
// cfg_no_ack_mode is set). Bytes beyond MAX_PAYLOAD are dropped and the
// packet is rejected. A 0x03 seen between packets reports a break. Write
// cfg_no_ack_mode only while no beats are in flight.
module rsp_packet_receiver
  import rsp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input beats
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_kind,
  input  wire logic [7:0]       in_rx_byte,
  // result beats
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            out_event_res,
  output logic [7:0]            out_payload_byte,
  output logic [LEN_W-1:0]      out_packet_length,
  output logic [1:0]            out_reject_reason,
  output logic                  out_reply_valid,
  output logic [7:0]            out_reply_byte,
  // configuration
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_no_ack_mode
);

  logic        s1_vld_r, s1_vld_nxt;
  logic        s1_kind_r;
  logic [7:0]  s1_byte_r;
  logic        out_vld_r, out_vld_nxt;
  rsp_result_t out_res_r;
  logic        no_ack_r;

  logic        out_free;
  logic        in_take;
  logic        step;
  logic        emit;
  rsp_result_t res;

  // Input register advances whenever the result register can take its outcome
  assign out_free   = !out_vld_r || !out_stall;
  assign in_stall   = s1_vld_r && !out_free;
  assign in_take    = in_valid && !in_stall;
  assign step       = s1_vld_r && out_free;
  assign s1_vld_nxt = in_take ? 1'b1 : (out_free ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = out_free ? (step && emit) : out_vld_r;
  assign cfg_ready  = 1'b1;

  rsp_frame_fsm #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .kind    (s1_kind_r),
    .rx_byte (s1_byte_r),
    .no_ack  (no_ack_r),
    .emit    (emit),
    .res     (res)
  );

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      no_ack_r  <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        no_ack_r <= cfg_no_ack_mode;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_rx_byte;
    end
    if (out_free && step && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_res     = out_res_r.event_res;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_packet_length = out_res_r.packet_length;
  assign out_reject_reason = out_res_r.reject_reason;
  assign out_reply_valid   = out_res_r.reply_valid;
  assign out_reply_byte    = out_res_r.reply_byte;

endmodule
`default_nettype wire

// ===== sv/rsp_frame_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "rsp_packet_receiver_macros.svh"
module rsp_frame_fsm
  import rsp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic        kind,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        no_ack,
  output logic             emit,
  output rsp_result_t      res
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_PAYLOAD = 3'd1;
  localparam logic [2:0] PH_ESCAPE  = 3'd2;
  localparam logic [2:0] PH_CSUM_HI = 3'd3;
  localparam logic [2:0] PH_CSUM_LO = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic             hi_bad_r, hi_bad_nxt;

  logic             store_en;
  logic [7:0]       store_byte;
  logic [4:0]       hex;
  logic [1:0]       reason;
  logic [CNT_W+LEN_W-1:0] cnt_ext;

  assign hex     = hex_nibble(rx_byte);
  assign cnt_ext = {{LEN_W{1'b0}}, cnt_r};

  // Frame state update for one beat
  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    hi_nxt     = hi_r;
    hi_bad_nxt = hi_bad_r;
    store_en   = 1'b0;
    store_byte = rx_byte;
    reason     = RSN_NONE;
    emit       = 1'b0;
    res        = '0;

    if (kind != KIND_BYTE) begin
      phase_nxt     = PH_HUNT;
      emit          = 1'b1;
      res.event_res = EV_ABORT;
    end else begin
      case (phase_r)
        PH_PAYLOAD: begin
          if (rx_byte == CHAR_END) begin
            phase_nxt = PH_CSUM_HI;
          end else begin
            sum_nxt = sum_r + rx_byte;
            if (rx_byte == CHAR_ESC) begin
              phase_nxt = PH_ESCAPE;
            end else begin
              store_en = 1'b1;
            end
          end
        end
        PH_ESCAPE: begin
          sum_nxt    = sum_r + rx_byte;
          phase_nxt  = PH_PAYLOAD;
          store_en   = 1'b1;
          store_byte = rx_byte ^ ESC_XOR;
        end
        PH_CSUM_HI: begin
          hi_bad_nxt = hex[4];
          hi_nxt     = hex[3:0];
          phase_nxt  = PH_CSUM_LO;
        end
        PH_CSUM_LO: begin
          phase_nxt = PH_HUNT;
          emit      = 1'b1;
          if (hi_bad_r || hex[4]) begin
            reason = RSN_BAD_HEX;
          end else if (ovf_r) begin
            reason = RSN_OVERFLOW;
          end else if ({hi_r, hex[3:0]} != sum_r) begin
            reason = RSN_MISMATCH;
          end
          if (reason != RSN_NONE) begin
            res.event_res     = EV_REJECT;
            res.reject_reason = reason;
            res.reply_valid   = !no_ack;
            res.reply_byte    = no_ack ? 8'h00 : CHAR_NAK;
          end else begin
            res.event_res     = EV_ACCEPT;
            res.packet_length = cnt_ext[LEN_W-1:0];
            res.reply_valid   = !no_ack;
            res.reply_byte    = no_ack ? 8'h00 : CHAR_ACK;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (rx_byte == CHAR_START) begin
            phase_nxt = PH_PAYLOAD;
            sum_nxt   = 8'h00;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else if (rx_byte == CHAR_BREAK) begin
            emit          = 1'b1;
            res.event_res = EV_BREAK;
          end
        end
      endcase

      // Store an unescaped byte, or drop it once the payload is full
      if (store_en) begin
        if (cnt_r < MAX_CNT) begin
          cnt_nxt          = cnt_r + CNT_W'(1);
          emit             = 1'b1;
          res.event_res    = EV_PAYLOAD;
          res.payload_byte = store_byte;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  // Advance state on each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      sum_r    <= '0;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      hi_r     <= '0;
      hi_bad_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      hi_r     <= hi_nxt;
      hi_bad_r <= hi_bad_nxt;
    end
  end

  `RSP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= MAX_CNT, "payload count beyond limit")
  `RSP_ASSERT_NOW(a_ovf_full, ovf_r, cnt_r == MAX_CNT, "overflow flagged before payload full")
  `RSP_ASSERT_NOW(a_reply_kind, emit && res.reply_valid,
                  res.event_res == EV_ACCEPT || res.event_res == EV_REJECT,
                  "reply on a non-terminal event")
  `RSP_ASSERT_NEXT(a_start, step && kind == KIND_BYTE && phase_r == PH_HUNT &&
                   rx_byte == CHAR_START,
                   phase_r == PH_PAYLOAD && cnt_r == '0 && sum_r == 8'h00 && !ovf_r,
                   "start marker did not open a clean packet")

endmodule
`default_nettype wire

// ===== verif/rsp_frame_checker.sv =====
`timescale 1ns / 1ps
module rsp_frame_checker
  import rsp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_kind,
  input  logic [7:0]       in_rx_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [2:0]       out_event_res,
  input  logic [7:0]       out_payload_byte,
  input  logic [LEN_W-1:0] out_packet_length,
  input  logic [1:0]       out_reject_reason,
  input  logic             out_reply_valid,
  input  logic [7:0]       out_reply_byte,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_no_ack_mode,
  output int               mismatches,
  output int               pending,
  output int               results_seen,
  output int               packets_accepted,
  output int               packets_rejected
);

  typedef enum logic [2:0] {
    F_HUNT,
    F_DATA,
    F_ESC,
    F_SUM_HI,
    F_SUM_LO
  } frame_st_e;

  // Shadow copy of the framing state
  frame_st_e   frame_st = F_HUNT;
  logic [7:0]  sum_acc = 8'h00;
  int unsigned kept = 0;
  logic        over = 1'b0;
  logic [3:0]  hi_nib = 4'h0;
  logic        hi_bad = 1'b0;
  logic        quiet = 1'b0;

  rsp_result_t due_q[$];
  int errs = 0;
  int seen = 0;
  int n_acc = 0;
  int n_rej = 0;

  // Value of an ASCII hex digit; bit 4 flags a non-digit
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b0, c[3:0]};
    end
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      return {1'b0, c[3:0] + 4'd9};
    end
    return 5'h10;
  endfunction

  function automatic rsp_result_t make_res(input logic [2:0] ev, input logic [7:0] pb,
                                           input logic [LEN_W-1:0] len,
                                           input logic [1:0] why, input logic rv,
                                           input logic [7:0] rb);
    rsp_result_t r;
    r.event_res     = ev;
    r.payload_byte  = pb;
    r.packet_length = len;
    r.reject_reason = why;
    r.reply_valid   = rv;
    r.reply_byte    = rb;
    return r;
  endfunction

  // Store one unescaped byte, or flag overflow once the buffer is full
  task automatic keep_byte(input logic [7:0] b);
    if (kept < MAX_PAYLOAD) begin
      kept++;
      due_q.push_back(make_res(EV_PAYLOAD, b, '0, RSN_NONE, 1'b0, 8'h00));
    end else begin
      over = 1'b1;
    end
  endtask

  // Advance the framing state by one accepted beat
  task automatic predict_beat(input logic k, input logic [7:0] b);
    logic [4:0] v;
    logic [1:0] why;
    if (k != KIND_BYTE) begin
      frame_st = F_HUNT;
      due_q.push_back(make_res(EV_ABORT, 8'h00, '0, RSN_NONE, 1'b0, 8'h00));
    end else begin
      case (frame_st)
        F_DATA: begin
          if (b == CHAR_END) begin
            frame_st = F_SUM_HI;
          end else begin
            sum_acc = sum_acc + b;
            if (b == CHAR_ESC) frame_st = F_ESC;
            else keep_byte(b);
          end
        end
        F_ESC: begin
          sum_acc = sum_acc + b;
          frame_st = F_DATA;
          keep_byte(b ^ ESC_XOR);
        end
        F_SUM_HI: begin
          v = digit_value(b);
          hi_bad = v[4];
          hi_nib = v[3:0];
          frame_st = F_SUM_LO;
        end
        F_SUM_LO: begin
          v = digit_value(b);
          frame_st = F_HUNT;
          why = RSN_NONE;
          if (hi_bad || v[4]) why = RSN_BAD_HEX;
          else if (over) why = RSN_OVERFLOW;
          else if ({hi_nib, v[3:0]} != sum_acc) why = RSN_MISMATCH;
          if (why != RSN_NONE) begin
            due_q.push_back(make_res(EV_REJECT, 8'h00, '0, why, !quiet,
                                     quiet ? 8'h00 : CHAR_NAK));
          end else begin
            due_q.push_back(make_res(EV_ACCEPT, 8'h00, LEN_W'(kept), RSN_NONE, !quiet,
                                     quiet ? 8'h00 : CHAR_ACK));
          end
        end
        default: begin
          frame_st = F_HUNT;
          if (b == CHAR_START) begin
            frame_st = F_DATA;
            sum_acc = 8'h00;
            kept = 0;
            over = 1'b0;
          end else if (b == CHAR_BREAK) begin
            due_q.push_back(make_res(EV_BREAK, 8'h00, '0, RSN_NONE, 1'b0, 8'h00));
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errs++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare result beats against the oldest prediction, then predict new ones
  always @(posedge clk) begin : watch
    rsp_result_t want;
    if (!rst_n) begin
      frame_st = F_HUNT;
      sum_acc = 8'h00;
      kept = 0;
      over = 1'b0;
      hi_nib = 4'h0;
      hi_bad = 1'b0;
      quiet = 1'b0;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          errs++;
          $display("%0t: expected no result beat, got event %0d", $time, out_event_res);
        end else begin
          want = due_q.pop_front();
          seen++;
          if (want.event_res == EV_ACCEPT) n_acc++;
          if (want.event_res == EV_REJECT) n_rej++;
          check_field("event", want.event_res, out_event_res);
          check_field("payload byte", want.payload_byte, out_payload_byte);
          check_field("packet length", want.packet_length, out_packet_length);
          check_field("reject reason", want.reject_reason, out_reject_reason);
          check_field("reply valid", want.reply_valid, out_reply_valid);
          check_field("reply byte", want.reply_byte, out_reply_byte);
        end
      end
      if (in_valid && !in_stall) predict_beat(in_kind, in_rx_byte);
      if (cfg_valid && cfg_ready) quiet = cfg_no_ack_mode;
    end
    mismatches       <= errs;
    pending          <= due_q.size();
    results_seen     <= seen;
    packets_accepted <= n_acc;
    packets_rejected <= n_rej;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rsp_pkg::*;

  localparam int   MAX_PAY       = 4096;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   HOLD_CYCLES   = 300;
  localparam logic KIND_LINK_FAIL = ~KIND_BYTE;

  typedef enum {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_HI,
    FR_BAD_LO,
    FR_CUT_BODY,
    FR_CUT_SUM
  } frame_how_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_kind = 1'b0;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       out_event_res;
  logic [7:0]       out_payload_byte;
  logic [LEN_W-1:0] out_packet_length;
  logic [1:0]       out_reject_reason;
  logic             out_reply_valid;
  logic [7:0]       out_reply_byte;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_no_ack_mode = 1'b0;

  int mism;
  int pending;
  int n_res;
  int n_acc;
  int n_rej;

  int snd_idle = 0;
  int rcv_stall = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int beats = 0;
  int noise_beats = 0;

  logic [7:0] body_q[$];

  always #5 clk = ~clk;

  rsp_packet_receiver #(
    .MAX_PAYLOAD(MAX_PAY)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_payload_byte (out_payload_byte),
    .out_packet_length(out_packet_length),
    .out_reject_reason(out_reject_reason),
    .out_reply_valid  (out_reply_valid),
    .out_reply_byte   (out_reply_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_no_ack_mode  (cfg_no_ack_mode)
  );

  rsp_frame_checker #(
    .MAX_PAYLOAD(MAX_PAY)
  ) u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_payload_byte (out_payload_byte),
    .out_packet_length(out_packet_length),
    .out_reject_reason(out_reject_reason),
    .out_reply_valid  (out_reply_valid),
    .out_reply_byte   (out_reply_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_no_ack_mode  (cfg_no_ack_mode),
    .mismatches       (mism),
    .pending          (pending),
    .results_seen     (n_res),
    .packets_accepted (n_acc),
    .packets_rejected (n_rej)
  );

  // Receiver backpressure: long hold on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h37 : 8'h57) + 8'(n);
  endfunction

  // Characters just outside the hex digit ranges, plus high bytes
  function automatic logic [7:0] not_hex();
    case ($urandom_range(0, 6))
      0: return 8'h2f;
      1: return 8'h3a;
      2: return 8'h40;
      3: return 8'h47;
      4: return 8'h60;
      5: return 8'h67;
      default: return 8'h80 | 8'($urandom_range(0, 127));
    endcase
  endfunction

  // Offer one beat after a random idle gap; hold it until taken
  task automatic send_beat(input logic k, input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= k;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    beats++;
  endtask

  // Drop valid and wait until every predicted result has drained
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic quiet);
    settle();
    cfg_valid       <= 1'b1;
    cfg_no_ack_mode <= quiet;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Build a raw payload of n logical bytes, some of them escaped
  task automatic fill_body(input int n);
    logic [7:0] b;
    body_q.delete();
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        body_q.push_back(CHAR_ESC);
        body_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        b = 8'($urandom_range(0, 255));
        while (b == CHAR_END || b == CHAR_ESC) b = 8'($urandom_range(0, 255));
        body_q.push_back(b);
      end
    end
  endtask

  // Frame the current body and send it, intact or damaged as asked
  task automatic send_frame(input frame_how_e how);
    logic [7:0] sum;
    int cut;
    sum = 8'h00;
    foreach (body_q[i]) sum = sum + body_q[i];
    if (how == FR_BAD_SUM) sum = sum + 8'($urandom_range(1, 255));
    cut = (how == FR_CUT_BODY) ? $urandom_range(0, body_q.size()) : body_q.size();
    send_beat(KIND_BYTE, CHAR_START);
    for (int i = 0; i < cut; i++) send_beat(KIND_BYTE, body_q[i]);
    if (how == FR_CUT_BODY) begin
      send_beat(KIND_LINK_FAIL, 8'($urandom_range(0, 255)));
      return;
    end
    send_beat(KIND_BYTE, CHAR_END);
    if (how == FR_CUT_SUM) begin
      if ($urandom_range(0, 1) == 1) send_beat(KIND_BYTE, hex_char(sum[7:4], 1'b0));
      send_beat(KIND_LINK_FAIL, 8'($urandom_range(0, 255)));
      return;
    end
    send_beat(KIND_BYTE, (how == FR_BAD_HI) ? not_hex() :
                         hex_char(sum[7:4], bit'($urandom_range(0, 1))));
    send_beat(KIND_BYTE, (how == FR_BAD_LO) ? not_hex() :
                         hex_char(sum[3:0], bit'($urandom_range(0, 1))));
  endtask

  // Mostly well-formed frames, with breaks, aborts, damage and line noise
  task automatic run_traffic(input int n);
    int start;
    int pick;
    frame_how_e how;
    start = beats;
    noise_beats = 0;
    while (beats - start - noise_beats < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_beat(KIND_BYTE, 8'($urandom_range(0, 255)) | 8'h40);
        noise_beats++;
      end else if (pick < 12) begin
        send_beat(KIND_BYTE, CHAR_BREAK);
      end else if (pick < 15) begin
        send_beat(KIND_LINK_FAIL, 8'($urandom_range(0, 255)));
      end else begin
        fill_body(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12));
        pick = $urandom_range(0, 99);
        if (pick < 70) how = FR_GOOD;
        else if (pick < 78) how = FR_BAD_SUM;
        else if (pick < 83) how = FR_BAD_HI;
        else if (pick < 88) how = FR_BAD_LO;
        else if (pick < 94) how = FR_CUT_BODY;
        else how = FR_CUT_SUM;
        send_frame(how);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: hunting noise, break, abort, escapes, checksum and hex rejects, cut frames
    send_beat(KIND_BYTE, 8'hff);
    send_beat(KIND_BYTE, CHAR_BREAK);
    send_beat(KIND_LINK_FAIL, 8'hff);
    body_q = '{CHAR_ESC, CHAR_END, CHAR_ESC, 8'h5d, CHAR_START};
    send_frame(FR_GOOD);
    body_q.delete();
    send_frame(FR_BAD_SUM);
    send_frame(FR_BAD_HI);
    send_frame(FR_BAD_LO);
    body_q = '{8'h41};
    send_frame(FR_CUT_BODY);
    body_q.delete();
    send_frame(FR_CUT_SUM);

    // Full buffer, overflow and reject priority, then a long receiver hold
    write_mode(1'b1);
    fill_body(MAX_PAY);
    send_frame(FR_GOOD);
    fill_body(MAX_PAY + 3);
    send_frame(FR_GOOD);
    fill_body(MAX_PAY + 1);
    send_frame(FR_BAD_SUM);
    fill_body(MAX_PAY + 2);
    send_frame(FR_BAD_HI);
    hold_asked <= hold_asked + 1;
    fill_body(120);
    send_frame(FR_GOOD);
    run_traffic(150);

    write_mode(1'b0);
    snd_idle = 63;
    run_traffic(150);

    write_mode(1'b1);
    snd_idle = 0;
    rcv_stall <= 63;
    run_traffic(150);

    write_mode(1'b0);
    snd_idle = 19;
    rcv_stall <= 19;
    run_traffic(150);

    settle();
    $display("Drove %0d input beats over four idle/stall mixes in both reply modes,",
             beats);
    $display("including full and overflowing payloads; %0d results checked, %0d %s",
             n_res, n_acc + n_rej, "packets closed.");
    if (mism == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
